// File: design/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Types and constants for the two-class Gaussian naive Bayes classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package gbc_pkg;

    // Field widths
    localparam int FEAT_W     = 16;            // signed Q8.8 feature / mean
    localparam int SD_W       = FEAT_W - 1;    // unsigned Q7.8 deviation
    localparam int CFG_IDX_W  = 3;
    localparam int LIK_W      = 32;            // unsigned Q8.24 likelihood

    // Datapath widths
    localparam int A_W        = 2 * FEAT_W;    // squared distance
    localparam int B_W        = 2 * SD_W + 1;  // 2*s^2
    localparam int D_W        = 2 * SD_W + 8;  // 157*s1*s2
    localparam int EXP_Q_W    = 30;            // exponent quotient bits kept
    localparam int EXP_FRAC_W = 24;            // exponent fraction bits
    localparam int EXP_PRE_W  = EXP_Q_W - EXP_FRAC_W;
    localparam int ESUM_W     = EXP_Q_W + 1;
    localparam int RECIP_W    = 17;
    localparam int EM_W       = ESUM_W + RECIP_W;
    localparam int RECIP_SH   = 40;
    localparam int K_W        = EM_W - RECIP_SH;
    localparam int KL_W       = 32;
    localparam int SHIFT_W    = 6;
    localparam int Q30_W      = 30;
    localparam int P_W        = Q30_W + 1;
    localparam int HORNER_N   = 6;
    localparam int NUM_W      = 46;
    localparam int OUT_Q_W    = 32;

    localparam logic [23:0]        LN2_Q24    = 24'd11629080;
    localparam logic [RECIP_W-1:0] LN2_RECIP  = 17'd94548;     // floor(2^40 / LN2_Q24)
    localparam logic [K_W-1:0]     K_LIMIT    = 8'd48;
    localparam logic [P_W-1:0]     ONE_Q30    = 31'h4000_0000;
    localparam logic [14:0]        NORM_SCALE = 15'd25600;
    localparam logic [7:0]         PI2_SCALE  = 8'd157;
    localparam logic [31:0]        RECIP3     = 32'hAAAA_AAAB;  // 2^33 / 3, rounded up
    localparam logic [31:0]        RECIP5     = 32'hCCCC_CCCD;  // 2^34 / 5, rounded up

    // Pipeline depth of one class lane, input register to likelihood
    localparam int LANE_LAT   = 2 + EXP_Q_W + 4 + 2 * HORNER_N + 2 + OUT_Q_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_C0_MEAN_ONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C0_MEAN_TWO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C0_SD_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C0_SD_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C1_MEAN_ONE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C1_MEAN_TWO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_C1_SD_ONE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_C1_SD_TWO   = 3'd7;

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_one;
        logic signed [FEAT_W-1:0] feature_two;
    } t_in_item;

    typedef struct packed {
        logic             chosen_class;
        logic [LIK_W-1:0] class0_likelihood;
        logic [LIK_W-1:0] class1_likelihood;
    } t_out_item;

    typedef struct packed {
        logic signed [FEAT_W-1:0] mean_one;
        logic signed [FEAT_W-1:0] mean_two;
        logic [SD_W-1:0]          sd_one;
        logic [SD_W-1:0]          sd_two;
    } t_class_cfg;

    typedef struct packed {
        logic zero;
        logic sat;
    } t_out_flags;

    // floor(t / j) for the Horner divisors 1..6
    function automatic logic [Q30_W-1:0] gbc_div_small(input logic [Q30_W-1:0] t,
                                                       input logic [2:0] j);
        logic [61:0]      prod;
        logic [Q30_W-1:0] q;
        prod = '0;
        case (j)
            3'd2: q = t >> 1;
            3'd3: begin
                prod = 62'(t) * 62'(RECIP3);
                q    = prod[33 +: Q30_W];
            end
            3'd4: q = t >> 2;
            3'd5: begin
                prod = 62'(t) * 62'(RECIP5);
                q    = prod[34 +: Q30_W];
            end
            3'd6: begin
                prod = 62'(t >> 1) * 62'(RECIP3);
                q    = prod[33 +: Q30_W];
            end
            default: q = t;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

// File: design/gbc_div.sv
// ----------------------------------------------------------------------------
// gbc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_div #(
    parameter int DEN_W = 31,
    parameter int QUO_W = 30,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DEN_W-1:0] i_rem,   // leading partial remainder, below i_den
    input  logic [QUO_W-1:0] i_low,   // dividend bits still to bring in
    input  logic [DEN_W-1:0] i_den,   // held stable while items are in flight
    input  logic [TAG_W-1:0] i_tag,
    output logic [QUO_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [TAG_W-1:0] r_tag [QUO_W];

    logic [DEN_W-1:0] s_rem [QUO_W];
    logic [QUO_W-1:0] s_low [QUO_W];
    logic [QUO_W-1:0] s_quo [QUO_W];
    logic [TAG_W-1:0] s_tag [QUO_W];
    logic [DEN_W:0]   trial [QUO_W];
    logic [DEN_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_quo [QUO_W];

    always_comb begin
        s_rem[0] = i_rem;
        s_low[0] = i_low;
        s_quo[0] = '0;
        s_tag[0] = i_tag;
        for (int i = 1; i < QUO_W; i++) begin
            s_rem[i] = r_rem[i-1];
            s_low[i] = r_low[i-1];
            s_quo[i] = r_quo[i-1];
            s_tag[i] = r_tag[i-1];
        end
        for (int i = 0; i < QUO_W; i++) begin
            trial[i] = {s_rem[i], s_low[i][QUO_W-1]};
            if (trial[i] >= {1'b0, i_den}) begin
                n_rem[i] = DEN_W'(trial[i] - {1'b0, i_den});
                n_quo[i] = {s_quo[i][QUO_W-2:0], 1'b1};
            end else begin
                n_rem[i] = trial[i][DEN_W-1:0];
                n_quo[i] = {s_quo[i][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < QUO_W; i++) begin
                r_rem[i] <= n_rem[i];
                r_low[i] <= {s_low[i][QUO_W-2:0], 1'b0};
                r_quo[i] <= n_quo[i];
                r_tag[i] <= s_tag[i];
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];
    assign o_tag = r_tag[QUO_W-1];

endmodule

`default_nettype wire

// File: design/gbc_lane.sv
// ----------------------------------------------------------------------------
// gbc_lane
// Joint Gaussian likelihood of one class: exponent dividers, range
// reduction by ln2, Horner exp, normalization divide.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_lane
    import gbc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  t_in_item         i_item,
    input  t_class_cfg       i_cfg,
    output logic [LIK_W-1:0] o_lik
);

    // Deviation-only terms, refreshed every cycle from the registers
    logic [SD_W-1:0]   sd1, sd2;
    logic [B_W-1:0]    r_b1, r_b2;
    logic [2*SD_W-1:0] r_s12;
    logic [D_W-1:0]    r_d;

    assign sd1 = (i_cfg.sd_one == '0) ? SD_W'(1) : i_cfg.sd_one;
    assign sd2 = (i_cfg.sd_two == '0) ? SD_W'(1) : i_cfg.sd_two;

    always_ff @(posedge i_clk) begin
        r_b1  <= {(2*SD_W)'(sd1) * (2*SD_W)'(sd1), 1'b0};
        r_b2  <= {(2*SD_W)'(sd2) * (2*SD_W)'(sd2), 1'b0};
        r_s12 <= sd1 * sd2;
        r_d   <= D_W'(r_s12) * D_W'(PI2_SCALE);
    end

    // Distance and square
    logic signed [FEAT_W:0] d1, d2;
    logic [FEAT_W-1:0]      r_mag1, r_mag2;
    logic [A_W-1:0]         r_a1, r_a2;

    assign d1 = {i_item.feature_one[FEAT_W-1], i_item.feature_one}
              - {i_cfg.mean_one[FEAT_W-1], i_cfg.mean_one};
    assign d2 = {i_item.feature_two[FEAT_W-1], i_item.feature_two}
              - {i_cfg.mean_two[FEAT_W-1], i_cfg.mean_two};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag1 <= d1[FEAT_W] ? FEAT_W'(-d1) : FEAT_W'(d1);
            r_mag2 <= d2[FEAT_W] ? FEAT_W'(-d2) : FEAT_W'(d2);
            r_a1   <= r_mag1 * r_mag1;
            r_a2   <= r_mag2 * r_mag2;
        end
    end

    // Exponent d^2 * 2^24 / (2 s^2); anything at 2^30 or more gives a zero density
    logic             big1, big2, ebig1, ebig2;
    logic [B_W-1:0]   rem1, rem2;
    logic [EXP_Q_W-1:0] e1, e2;

    assign big1 = (B_W+EXP_PRE_W)'(r_a1) >= {r_b1, {EXP_PRE_W{1'b0}}};
    assign big2 = (B_W+EXP_PRE_W)'(r_a2) >= {r_b2, {EXP_PRE_W{1'b0}}};
    assign rem1 = big1 ? '0 : B_W'(r_a1[A_W-1:EXP_PRE_W]);
    assign rem2 = big2 ? '0 : B_W'(r_a2[A_W-1:EXP_PRE_W]);

    gbc_div #(.DEN_W(B_W), .QUO_W(EXP_Q_W), .TAG_W(1)) u_div_f1 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_rem (rem1),
        .i_low ({r_a1[EXP_PRE_W-1:0], {EXP_FRAC_W{1'b0}}}),
        .i_den (r_b1),
        .i_tag (big1),
        .o_quo (e1),
        .o_tag (ebig1)
    );

    gbc_div #(.DEN_W(B_W), .QUO_W(EXP_Q_W), .TAG_W(1)) u_div_f2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_rem (rem2),
        .i_low ({r_a2[EXP_PRE_W-1:0], {EXP_FRAC_W{1'b0}}}),
        .i_den (r_b2),
        .i_tag (big2),
        .o_quo (e2),
        .o_tag (ebig2)
    );

    // E = k*ln2 + r, k from a reciprocal estimate that may be one low
    logic [ESUM_W-1:0] r_esum, r_e34, r_e35;
    logic              r_big33, r_big34, r_big35;
    logic [EM_W-1:0]   r_em;
    logic [K_W-1:0]    r_kest;
    logic [KL_W-1:0]   r_kl;
    logic [ESUM_W-1:0] rdiff;
    logic              rfix;
    logic [K_W-1:0]    kfix;
    logic [23:0]       rred;
    logic [Q30_W-1:0]  r_r;
    logic [SHIFT_W-1:0] r_k;
    logic              r_zero;

    assign rdiff = r_e35 - ESUM_W'(r_kl);
    assign rfix  = rdiff >= ESUM_W'(LN2_Q24);
    assign kfix  = rfix ? r_kest + K_W'(1) : r_kest;
    assign rred  = rfix ? 24'(rdiff - ESUM_W'(LN2_Q24)) : rdiff[23:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_esum  <= ESUM_W'(e1) + ESUM_W'(e2);
            r_big33 <= ebig1 | ebig2;
            r_em    <= EM_W'(r_esum) * EM_W'(LN2_RECIP);
            r_e34   <= r_esum;
            r_big34 <= r_big33;
            r_kest  <= r_em[EM_W-1:RECIP_SH];
            r_kl    <= KL_W'(r_em[EM_W-1:RECIP_SH]) * KL_W'(LN2_Q24);
            r_e35   <= r_e34;
            r_big35 <= r_big34;
            r_r     <= {rred, {EXP_PRE_W{1'b0}}};
            r_k     <= kfix[SHIFT_W-1:0];
            r_zero  <= r_big35 | (kfix >= K_LIMIT);
        end
    end

    // Horner exp(-r), two stages per term: product, then divide by j
    localparam int HS = 2 * HORNER_N;

    logic [Q30_W-1:0]   r_ht [HORNER_N];
    logic [P_W-1:0]     r_hp [HORNER_N];
    logic [Q30_W-1:0]   r_cr [HS];
    logic [SHIFT_W-1:0] r_ck [HS];
    logic               r_cz [HS];
    logic [Q30_W-1:0]   h_r  [HS];
    logic [SHIFT_W-1:0] h_k  [HS];
    logic               h_z  [HS];
    logic [P_W-1:0]     h_p  [HORNER_N];
    logic [61:0]        h_prod [HORNER_N];

    always_comb begin
        h_r[0] = r_r;
        h_k[0] = r_k;
        h_z[0] = r_zero;
        for (int s = 1; s < HS; s++) begin
            h_r[s] = r_cr[s-1];
            h_k[s] = r_ck[s-1];
            h_z[s] = r_cz[s-1];
        end
        h_p[0] = ONE_Q30;
        for (int i = 1; i < HORNER_N; i++) begin
            h_p[i] = r_hp[i-1];
        end
        for (int i = 0; i < HORNER_N; i++) begin
            h_prod[i] = 62'(h_r[2*i]) * 62'(h_p[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < HS; s++) begin
                r_cr[s] <= h_r[s];
                r_ck[s] <= h_k[s];
                r_cz[s] <= h_z[s];
            end
            for (int i = 0; i < HORNER_N; i++) begin
                r_ht[i] <= h_prod[i][Q30_W +: Q30_W];
                r_hp[i] <= ONE_Q30 - P_W'(gbc_div_small(r_ht[i], 3'(HORNER_N - i)));
            end
        end
    end

    // Normalization: floor((p*25600 >> k) / (157*s1*s2))
    logic [NUM_W-1:0]   r_num, r_sh;
    logic [SHIFT_W-1:0] r_k49;
    logic               r_z49, r_z50;
    logic [D_W-1:0]     orem;
    logic               osat;
    t_out_flags         oflags_in, oflags;
    logic [OUT_Q_W-1:0] oquo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= NUM_W'(r_hp[HORNER_N-1]) * NUM_W'(NORM_SCALE);
            r_k49 <= r_ck[HS-1];
            r_z49 <= r_cz[HS-1];
            r_sh  <= r_num >> r_k49;
            r_z50 <= r_z49;
        end
    end

    assign osat      = D_W'(r_sh[NUM_W-1:OUT_Q_W]) >= r_d;
    assign orem      = osat ? '0 : D_W'(r_sh[NUM_W-1:OUT_Q_W]);
    assign oflags_in = '{zero: r_z50, sat: osat};

    gbc_div #(.DEN_W(D_W), .QUO_W(OUT_Q_W), .TAG_W($bits(t_out_flags))) u_div_out (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_rem (orem),
        .i_low (r_sh[OUT_Q_W-1:0]),
        .i_den (r_d),
        .i_tag (oflags_in),
        .o_quo (oquo),
        .o_tag (oflags)
    );

    assign o_lik = oflags.zero ? '0 : (oflags.sat ? '1 : LIK_W'(oquo));

endmodule

`default_nettype wire

// File: design/gaussian_bayes_two_class_classifier_top.sv
// ----------------------------------------------------------------------------
// gaussian_bayes_two_class_classifier_top
// Two-class, two-feature Gaussian naive Bayes classifier.
// ----------------------------------------------------------------------------
// Takes one feature pair per clock unless o_stall is high and returns one
// result per item, in order. The depth is set mostly by the bit-per-stage
// restoring dividers in each class lane (30 stages for the two exponent
// dividers, 32 for the density normalization) plus the 12-stage Horner exp.
// The two classes run in parallel lanes; a compare stage picks the class,
// ties going to class 1. The pipeline keeps moving while a result waits in
// the output register and only holds when a finished item has nowhere to go.
// Configuration may only be written while no item is in flight.
`default_nettype none

module gaussian_bayes_two_class_classifier_top
    import gbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FEAT_W-1:0]    i_cfg_data
);

    t_class_cfg r_cfg0, r_cfg1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg0 <= '{mean_one: '0, mean_two: '0, sd_one: SD_W'(256), sd_two: SD_W'(256)};
            r_cfg1 <= '{mean_one: '0, mean_two: '0, sd_one: SD_W'(256), sd_two: SD_W'(256)};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_C0_MEAN_ONE: r_cfg0.mean_one <= i_cfg_data;
                CFG_C0_MEAN_TWO: r_cfg0.mean_two <= i_cfg_data;
                CFG_C0_SD_ONE:   r_cfg0.sd_one   <= i_cfg_data[SD_W-1:0];
                CFG_C0_SD_TWO:   r_cfg0.sd_two   <= i_cfg_data[SD_W-1:0];
                CFG_C1_MEAN_ONE: r_cfg1.mean_one <= i_cfg_data;
                CFG_C1_MEAN_TWO: r_cfg1.mean_two <= i_cfg_data;
                CFG_C1_SD_ONE:   r_cfg1.sd_one   <= i_cfg_data[SD_W-1:0];
                CFG_C1_SD_TWO:   r_cfg1.sd_two   <= i_cfg_data[SD_W-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: hold only when the last stage is full and can't unload
    logic                en;
    logic                accept;
    logic [LANE_LAT-1:0] r_vld;
    logic                r_out_vld;
    t_out_item           r_out;
    logic [LIK_W-1:0]    lik0, lik1;

    assign en      = !(r_vld[LANE_LAT-1] && r_out_vld && i_stall);
    assign o_stall = !en;
    assign accept  = i_valid && en;

    gbc_lane u_lane0 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_item (i_data),
        .i_cfg  (r_cfg0),
        .o_lik  (lik0)
    );

    gbc_lane u_lane1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_item (i_data),
        .i_cfg  (r_cfg1),
        .o_lik  (lik1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LANE_LAT-2:0], accept};
            end
            if (en && r_vld[LANE_LAT-1]) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld[LANE_LAT-1]) begin
            r_out.chosen_class      <= (lik0 > lik1) ? 1'b0 : 1'b1;
            r_out.class0_likelihood <= lik0;
            r_out.class1_likelihood <= lik1;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LANE_LAT-1] && o_valid && i_stall) |-> o_stall)
        else $error("pipeline advanced over an undelivered result");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with output free");

    a_class_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.chosen_class
                     == (o_data.class0_likelihood <= o_data.class1_likelihood)))
        else $error("chosen class disagrees with likelihoods");

endmodule

`default_nettype wire

// File: dv/gaussian_bayes_two_class_classifier_top_tb.sv
// ----------------------------------------------------------------------------
// gaussian_bayes_two_class_classifier_top_tb
// Streams feature pairs through the classifier under several class settings,
// with bursty input and a stalling output, and compares every result against
// a bit-exact fixed-point predictor of both class likelihoods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gaussian_bayes_two_class_classifier_top_tb;
    import gbc_pkg::*;

    localparam int          CLK_PERIOD = 8;
    localparam int          PIPE_LAT   = 83;
    localparam longint      CYCLE_MAX  = 400000;
    localparam logic [63:0] LN2_Q24_V  = 64'd11629080;
    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] EXP_SAT    = 64'd1 << 48;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_in_item             i_data;
    logic                 o_valid;
    logic                 i_stall;
    t_out_item            o_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [FEAT_W-1:0]    i_cfg_data;

    gaussian_bayes_two_class_classifier_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor copy of the class registers
    t_class_cfg cls_cfg [2];

    t_out_item  pending_results [$];
    int         n_errors;
    int         n_checked;
    int         n_sent;
    longint     cycle_cnt;
    bit         long_hold;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX) begin
            $display("%0t timeout, %0d results outstanding", $time, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // floor(a * 2^24 / b), capped so the density collapses to zero
    function automatic logic [63:0] exp_term(input logic signed [FEAT_W-1:0] x,
                                             input logic signed [FEAT_W-1:0] mu,
                                             input logic [SD_W-1:0] sd);
        longint      d;
        logic [63:0] a, b, q, r, s;
        d = longint'(x) - longint'(mu);
        if (d < 0) d = -d;
        a = d * d;
        s = (sd == '0) ? 64'd1 : 64'(sd);
        b = 2 * s * s;
        q = a / b;
        r = a % b;
        if (q >= (64'd1 << 24)) return EXP_SAT;
        for (int i = 0; i < 24; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= b) begin
                r = r - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [31:0] class_density(input t_in_item it, input t_class_cfg c);
        logic [63:0] e, k, r, p, s1, s2, q, v;
        e = exp_term(it.feature_one, c.mean_one, c.sd_one)
            + exp_term(it.feature_two, c.mean_two, c.sd_two);
        k = e / LN2_Q24_V;
        r = (e - k * LN2_Q24_V) << 6;
        if (k + 16 >= 64) return 32'd0;
        p = Q30_ONE;
        for (int j = 6; j >= 1; j--)
            p = Q30_ONE - ((r * p) >> 30) / j;
        s1 = (c.sd_one == '0) ? 64'd1 : 64'(c.sd_one);
        s2 = (c.sd_two == '0) ? 64'd1 : 64'(c.sd_two);
        q = ((p * 64'd25600) << 16) / (64'd157 * s1) / s2;
        v = q >> (k + 16);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic t_out_item classify(input t_in_item it);
        t_out_item res;
        res.class0_likelihood = class_density(it, cls_cfg[0]);
        res.class1_likelihood = class_density(it, cls_cfg[1]);
        res.chosen_class = (res.class0_likelihood > res.class1_likelihood) ? 1'b0 : 1'b1;
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FEAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_C0_MEAN_ONE: cls_cfg[0].mean_one = val;
            CFG_C0_MEAN_TWO: cls_cfg[0].mean_two = val;
            CFG_C0_SD_ONE:   cls_cfg[0].sd_one   = val[SD_W-1:0];
            CFG_C0_SD_TWO:   cls_cfg[0].sd_two   = val[SD_W-1:0];
            CFG_C1_MEAN_ONE: cls_cfg[1].mean_one = val;
            CFG_C1_MEAN_TWO: cls_cfg[1].mean_two = val;
            CFG_C1_SD_ONE:   cls_cfg[1].sd_one   = val[SD_W-1:0];
            default:         cls_cfg[1].sd_two   = val[SD_W-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_classes(input t_class_cfg c0, input t_class_cfg c1);
        write_reg(CFG_C0_MEAN_ONE, c0.mean_one);
        write_reg(CFG_C0_MEAN_TWO, c0.mean_two);
        write_reg(CFG_C0_SD_ONE, FEAT_W'(c0.sd_one));
        write_reg(CFG_C0_SD_TWO, FEAT_W'(c0.sd_two));
        write_reg(CFG_C1_MEAN_ONE, c1.mean_one);
        write_reg(CFG_C1_MEAN_TWO, c1.mean_two);
        write_reg(CFG_C1_SD_ONE, FEAT_W'(c1.sd_one));
        write_reg(CFG_C1_SD_TWO, FEAT_W'(c1.sd_two));
    endtask

    // present one item at the current edge, hold it until accepted;
    // optional idle gap first. Returns at the accepting edge with valid
    // still high so the next item can follow without a gap.
    task automatic send_item(input t_in_item it, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        pending_results.push_back(classify(it));
        n_sent++;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    function automatic logic [FEAT_W-1:0] rand_feat();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return FEAT_W'($urandom());
            default: return FEAT_W'($signed($urandom_range(0, 1536)) - 768);
        endcase
    endfunction

    function automatic logic [SD_W-1:0] rand_sd();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return SD_W'($urandom());
            default: return SD_W'($urandom_range(16, 1024));
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        t_in_item it;
        t_in_item base;
        int       burst;
        int       gap;
        base.feature_one = cls_cfg[$urandom_range(0, 1)].mean_one;
        base.feature_two = cls_cfg[$urandom_range(0, 1)].mean_two;
        while (n_items > 0) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && n_items > 0; b++) begin
                if ($urandom_range(0, 2) == 0) begin
                    it.feature_one = rand_feat();
                    it.feature_two = rand_feat();
                end else begin
                    // near a class mean, where densities can be nonzero
                    it.feature_one = base.feature_one + FEAT_W'($signed($urandom_range(0, 1024)) - 512);
                    it.feature_two = base.feature_two + FEAT_W'($signed($urandom_range(0, 1024)) - 512);
                end
                send_item(it, 0);
                n_items--;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // receiver: stalls on its own pattern, with one long hold-off
    initial begin
        int hold;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                hold = 300;
                while (hold > 0) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                    hold--;
                end
                long_hold = 1'b0;
            end
            case ((cycle_cnt / 512) % 3)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, o_data);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_data.chosen_class !== want.chosen_class) begin
                    $display("%0t class: expected %0d actual %0d", $time,
                             want.chosen_class, o_data.chosen_class);
                    n_errors++;
                end
                if (o_data.class0_likelihood !== want.class0_likelihood) begin
                    $display("%0t class0 likelihood: expected %h actual %h", $time,
                             want.class0_likelihood, o_data.class0_likelihood);
                    n_errors++;
                end
                if (o_data.class1_likelihood !== want.class1_likelihood) begin
                    $display("%0t class1 likelihood: expected %h actual %h", $time,
                             want.class1_likelihood, o_data.class1_likelihood);
                    n_errors++;
                end
            end
        end
    end

    typedef struct {
        logic [FEAT_W-1:0] f1;
        logic [FEAT_W-1:0] f2;
        bit                known;
        logic              cls;
        logic [31:0]       l0;
        logic [31:0]       l1;
    } t_vec;

    // reset settings: both classes identical, so every item ties to class 1
    localparam int N_DIR = 10;
    t_vec dir_tab [N_DIR] = '{
        '{16'h0000, 16'h0000, 1'b0, 1'b1, 32'h0, 32'h0},
        '{16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 32'h0, 32'h0},
        '{16'h8000, 16'h8000, 1'b1, 1'b1, 32'h0, 32'h0},
        '{16'h7FFF, 16'h8000, 1'b1, 1'b1, 32'h0, 32'h0},
        '{16'h0100, 16'h0000, 1'b0, 1'b1, 32'h0, 32'h0},
        '{16'hFF00, 16'h0080, 1'b0, 1'b1, 32'h0, 32'h0},
        '{16'h0001, 16'hFFFF, 1'b0, 1'b1, 32'h0, 32'h0},
        '{16'h0400, 16'h0000, 1'b0, 1'b1, 32'h0, 32'h0},
        '{16'h5555, 16'hAAAA, 1'b1, 1'b1, 32'h0, 32'h0},
        '{16'h0C00, 16'hF400, 1'b1, 1'b1, 32'h0, 32'h0}
    };

    initial begin
        t_in_item   it;
        t_out_item  typed;
        t_class_cfg c0, c1;
        cycle_cnt  = 0;
        n_errors   = 0;
        n_checked  = 0;
        n_sent     = 0;
        long_hold  = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        for (int c = 0; c < 2; c++) begin
            cls_cfg[c].mean_one = '0;
            cls_cfg[c].mean_two = '0;
            cls_cfg[c].sd_one   = SD_W'(256);
            cls_cfg[c].sd_two   = SD_W'(256);
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            it.feature_one = dir_tab[i].f1;
            it.feature_two = dir_tab[i].f2;
            if (dir_tab[i].known) begin
                typed.chosen_class      = dir_tab[i].cls;
                typed.class0_likelihood = dir_tab[i].l0;
                typed.class1_likelihood = dir_tab[i].l1;
                if (typed !== classify(it)) begin
                    $display("%0t table row %0d: expected %h predicted %h", $time, i,
                             typed, classify(it));
                    n_errors++;
                end
            end
            send_item(it, i % 3);
        end
        drain();

        // extreme settings: tiny deviations saturate, zero deviation acts as one
        c0 = '{mean_one: 16'h0000, mean_two: 16'h0000, sd_one: '0, sd_two: SD_W'(1)};
        c1 = '{mean_one: 16'h7FFF, mean_two: 16'h8000, sd_one: '1, sd_two: '1};
        load_classes(c0, c1);
        it = '{feature_one: 16'h0000, feature_two: 16'h0000};
        send_item(it, 0);
        it = '{feature_one: 16'h7FFF, feature_two: 16'h8000};
        send_item(it, 0);
        it = '{feature_one: 16'h0001, feature_two: 16'hFFFF};
        send_item(it, 0);
        random_phase(80);
        drain();

        // long receiver hold-off while the sender keeps pushing
        c0 = '{mean_one: 16'h0100, mean_two: 16'hFF00, sd_one: SD_W'(256), sd_two: SD_W'(128)};
        c1 = '{mean_one: 16'hFF00, mean_two: 16'h0100, sd_one: SD_W'(512), sd_two: SD_W'(256)};
        load_classes(c0, c1);
        long_hold = 1'b1;
        random_phase(200);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            c0 = '{mean_one: rand_feat(), mean_two: rand_feat(), sd_one: rand_sd(),
                   sd_two: rand_sd()};
            c1 = '{mean_one: rand_feat(), mean_two: rand_feat(), sd_one: rand_sd(),
                   sd_two: rand_sd()};
            load_classes(c0, c1);
            random_phase(180);
            drain();
        end

        $display("sent %0d items over 7 class settings, %0d results compared",
                 n_sent, n_checked);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
